FILE: hw/rtl/number_to_ascii_digits_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the number to ASCII digits block
// Each macro expands to a clocked concurrent assertion, or to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_ASCII_DIGITS_MACROS_SVH
`define NUMBER_TO_ASCII_DIGITS_MACROS_SVH

`ifndef SYNTHESIS
// The property must hold at every clock edge outside reset.
`define N2A_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// The condition must never be true at a clock edge outside reset.
`define N2A_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define N2A_ASSERT(lbl, prop, msg)
`define N2A_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

FILE: hw/rtl/n2a_pkg.sv
// ----------------------------------------------------------------------------
// n2a_pkg
// Types, character codes and helpers shared by the number formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package n2a_pkg;

	localparam logic [1:0] MODE_UDEC = 2'd0;
	localparam logic [1:0] MODE_SDEC = 2'd1;
	localparam logic [1:0] MODE_HEX  = 2'd2;
	localparam logic [1:0] MODE_BIN  = 2'd3;

	localparam logic [6:0] CH_PLUS  = 7'd43;
	localparam logic [6:0] CH_MINUS = 7'd45;
	localparam logic [6:0] CH_ZERO  = 7'd48;
	localparam logic [6:0] CH_A     = 7'd65;

	localparam logic [4:0] LIM_DEC = 5'd10;
	localparam logic [4:0] LIM_HEX = 5'd8;
	localparam logic [4:0] LIM_BIN = 5'd16;

	localparam int MAX_DIGITS = 16;

	// Reciprocal of ten: floor(n / 10) == (n * RECIP10) >> 35 for any 32-bit n.
	localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One formatted number, ready to be turned into characters.
	// digits[0] is the least significant digit.
	typedef struct packed {
		logic [2:0]                  line;
		logic [4:0]                  col;
		logic                        has_sign;
		logic                        neg;
		logic [4:0]                  cnt;
		logic [MAX_DIGITS-1:0][3:0]  digits;
	} n2a_cmd_t;

	function automatic logic [6:0] digit_char(input logic [3:0] d);
		logic [6:0] ch;
		if (d < 4'd10) begin
			ch = CH_ZERO + {3'b000, d};
		end else begin
			ch = CH_A + {3'b000, d} - 7'd10;
		end
		return ch;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/n2a_in_if.sv
// ----------------------------------------------------------------------------
// n2a_in_if
// Input channel: one number with its format and screen position per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface n2a_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  mode;
	logic [31:0] value;
	logic [4:0]  digit_count;
	logic [2:0]  text_line;
	logic [4:0]  start_column;

	modport source (
		output valid, mode, value, digit_count, text_line, start_column,
		input  ready
	);
	modport sink (
		input  valid, mode, value, digit_count, text_line, start_column,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/n2a_out_if.sv
// ----------------------------------------------------------------------------
// n2a_out_if
// Output channel: one display character with its position per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface n2a_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] out_line;
	logic [5:0] out_column;
	logic [6:0] char_code;
	logic       last;

	modport source (
		output valid, out_line, out_column, char_code, last,
		input  ready
	);
	modport sink (
		input  valid, out_line, out_column, char_code, last,
		output ready
	);
endinterface

`default_nettype wire

FILE: hw/rtl/n2a_front.sv
// ----------------------------------------------------------------------------
// n2a_front
// Accepts numbers, saturates the digit count, takes the sign and splits the
// value into digits (one decimal digit per cycle), then queues the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_ascii_digits_macros.svh"

module n2a_front (
	input  wire logic          clk,
	input  wire logic          arst_n,
	n2a_in_if.sink             num,
	input  wire logic          q_full,
	output logic               q_push,
	output n2a_pkg::n2a_cmd_t  q_data
);
	import n2a_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PEEL = 2'd1;
	localparam logic [1:0] ST_PUSH = 2'd2;

	logic [1:0]  state_q;
	n2a_cmd_t    cmd_q;
	logic [31:0] val_q;
	logic [3:0]  k_q;

	logic        accept;
	logic [4:0]  lim;
	logic [4:0]  cnt_sat;
	logic        neg;
	logic [31:0] mag;
	logic        is_dec;
	n2a_cmd_t    cmd_new;
	logic [63:0] prod;
	logic [31:0] quot;
	logic [31:0] rem_full;
	logic [4:0]  cnt_m1;

	assign num.ready = (state_q == ST_IDLE);
	assign accept    = num.valid && num.ready;
	assign q_push    = (state_q == ST_PUSH) && !q_full;
	assign q_data    = cmd_q;

	always_comb begin
		case (num.mode)
			MODE_UDEC: lim = LIM_DEC;
			MODE_SDEC: lim = LIM_DEC;
			MODE_HEX:  lim = LIM_HEX;
			default:   lim = LIM_BIN;
		endcase
		cnt_sat = (num.digit_count > lim) ? lim : num.digit_count;
		is_dec  = (num.mode == MODE_UDEC) || (num.mode == MODE_SDEC);
		neg     = (num.mode == MODE_SDEC) && num.value[31];
		mag     = neg ? (32'd0 - num.value) : num.value;

		cmd_new          = '0;
		cmd_new.line     = num.text_line;
		cmd_new.col      = num.start_column;
		cmd_new.has_sign = (num.mode == MODE_SDEC);
		cmd_new.neg      = neg;
		cmd_new.cnt      = cnt_sat;
		// Hex and binary digits are plain bit fields; decimal ones are filled later.
		for (int i = 0; i < MAX_DIGITS; i++) begin
			if (num.mode == MODE_HEX) begin
				cmd_new.digits[i] = (i < 8) ? num.value[4*(i%8) +: 4] : 4'd0;
			end else if (num.mode == MODE_BIN) begin
				cmd_new.digits[i] = {3'b000, num.value[i]};
			end else begin
				cmd_new.digits[i] = 4'd0;
			end
		end
	end

	// One division by ten per cycle through the reciprocal multiply.
	always_comb begin
		prod     = 64'(val_q) * 64'(RECIP10);
		quot     = {3'b000, prod[63:35]};
		rem_full = val_q - {quot[28:0], 3'b000} - {quot[30:0], 1'b0};
		cnt_m1   = cmd_q.cnt - 5'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						k_q     <= '0;
						state_q <= (is_dec && (cnt_sat != 5'd0)) ? ST_PEEL : ST_PUSH;
					end
				end
				ST_PEEL: begin
					k_q <= k_q + 4'd1;
					if (k_q == cnt_m1[3:0]) begin
						state_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					if (!q_full) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd_new;
			val_q <= mag;
		end else if (state_q == ST_PEEL) begin
			cmd_q.digits[k_q] <= rem_full[3:0];
			val_q             <= quot;
		end
	end

	`N2A_ASSERT(a_peel_has_count, (state_q == ST_PEEL) |-> (cmd_q.cnt != 5'd0) && (cmd_q.cnt <= LIM_DEC), "digit extraction without a decimal count")
	`N2A_ASSERT(a_peel_in_range, (state_q == ST_PEEL) |-> ({1'b0, k_q} < cmd_q.cnt), "digit index beyond count")

endmodule

`default_nettype wire

FILE: hw/rtl/n2a_queue.sv
// ----------------------------------------------------------------------------
// n2a_queue
// Short first-in first-out queue of formatted numbers between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_ascii_digits_macros.svh"

module n2a_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire n2a_pkg::n2a_cmd_t push_data,
	output logic                   full,
	input  wire logic              pop,
	output n2a_pkg::n2a_cmd_t      head,
	output logic                   empty
);
	import n2a_pkg::*;

	n2a_cmd_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	assign full  = (count_q == QCNT_W'(QDEPTH));
	assign empty = (count_q == '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`N2A_ASSERT_NEVER(a_no_overflow, push && full, "push into a full queue")
	`N2A_ASSERT_NEVER(a_no_underflow, pop && empty, "pop from an empty queue")

endmodule

`default_nettype wire

FILE: hw/rtl/n2a_back.sv
// ----------------------------------------------------------------------------
// n2a_back
// Takes formatted numbers from the queue and emits one character per cycle while
// the receiver is ready, sign first, then digits most significant first, through an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_ascii_digits_macros.svh"

module n2a_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire n2a_pkg::n2a_cmd_t head,
	input  wire logic              q_empty,
	output logic                   q_pop,
	n2a_out_if.source              chr
);
	import n2a_pkg::*;

	logic       active_q;
	logic       sign_done_q;
	logic [4:0] rem_q;
	logic [5:0] col_q;

	logic       valid_q;
	logic [2:0] line_q;
	logic [5:0] column_q;
	logic [6:0] char_q;
	logic       last_q;

	logic       slot_free;
	logic       skip;
	logic       load;
	logic       emit;
	logic       is_last;
	logic [4:0] idx;
	logic [6:0] ch;

	assign chr.valid      = valid_q;
	assign chr.out_line   = line_q;
	assign chr.out_column = column_q;
	assign chr.char_code  = char_q;
	assign chr.last       = last_q;

	always_comb begin
		slot_free = !valid_q || chr.ready;
		// A number with no sign and no digits produces nothing.
		skip      = !active_q && !q_empty && !head.has_sign && (head.cnt == 5'd0);
		load      = !active_q && !q_empty && !skip;
		emit      = active_q && slot_free;
		idx       = rem_q - 5'd1;
		if (!sign_done_q) begin
			is_last = (head.cnt == 5'd0);
			ch      = head.neg ? CH_MINUS : CH_PLUS;
		end else begin
			is_last = (rem_q == 5'd1);
			ch      = digit_char(head.digits[idx[3:0]]);
		end
		q_pop = skip || (emit && is_last);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			sign_done_q <= 1'b0;
			rem_q       <= '0;
			valid_q     <= 1'b0;
		end else begin
			if (load) begin
				active_q    <= 1'b1;
				sign_done_q <= !head.has_sign;
				rem_q       <= head.cnt;
			end else if (emit) begin
				if (is_last) begin
					active_q <= 1'b0;
				end
				if (!sign_done_q) begin
					sign_done_q <= 1'b1;
				end else begin
					rem_q <= rem_q - 5'd1;
				end
			end
			if (emit) begin
				valid_q <= 1'b1;
			end else if (chr.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			col_q <= {1'b0, head.col};
		end else if (emit) begin
			col_q <= col_q + 6'd1;
		end
		if (emit) begin
			line_q   <= head.line;
			column_q <= col_q;
			char_q   <= ch;
			last_q   <= is_last;
		end
	end

	`N2A_ASSERT(a_active_has_head, active_q |-> !q_empty, "emitting without a queued number")
	`N2A_ASSERT(a_digits_left, (active_q && sign_done_q) |-> (rem_q != 5'd0), "digit phase with no digits left")

endmodule

`default_nettype wire

FILE: hw/rtl/number_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// number_to_ascii_digits
// Formats a 32-bit number as fixed-width display characters, one per item.
// ----------------------------------------------------------------------------
// Channel num takes one number per item: format mode, value, digit count,
// text line and start column. Channel chr gives one character per item with
// its line, column and a last flag on the final character of the number.
// Both channels move an item on a clock edge where valid and ready are high.
// The front accepts a number, then splits off its decimal digits one at a time
// by a reciprocal multiply by ten (hex and binary digits need no such step)
// and enqueues it; it takes no new number until that one is in the queue.
// A two-entry queue parts the front from the back, so the next number is
// split while the current one is printed. The back picks up a number from
// the queue and then emits its characters one at a time, sign included.
// Reset clears all control state and drops any queued or pending item.
// When the receiver holds ready low, the output register keeps its item,
// the back stops, the queue fills and then num.ready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module number_to_ascii_digits (
	input  wire logic clk,
	input  wire logic arst_n,
	n2a_in_if.sink    num,
	n2a_out_if.source chr
);
	import n2a_pkg::*;

	n2a_cmd_t push_data;
	n2a_cmd_t head;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	n2a_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.num       (num),
		.q_full    (full),
		.q_push    (push),
		.q_data    (push_data)
	);

	n2a_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	n2a_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_empty   (empty),
		.q_pop     (pop),
		.chr       (chr)
	);

endmodule

`default_nettype wire

FILE: test/tb_number_to_ascii_digits.sv
// ----------------------------------------------------------------------------
// tb_number_to_ascii_digits
// Self-checking bench for the number formatter.
// ----------------------------------------------------------------------------
// Numbers go in on the num channel. Each accepted number is expanded right
// away into the display characters it should produce, and every character on
// the chr channel is checked field by field against the oldest one still
// waiting. A directed set covers the field extremes, every format and the
// sign-only, saturated-count and most-negative cases. Random numbers then
// follow in bursts, with the receiver free, stalling at random or in a pattern. One long receiver
// hold-off fills the block up, and some bursts wait for every character to
// drain before going on.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_number_to_ascii_digits;
	import n2a_pkg::*;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] value;
		logic [4:0]  digit_count;
		logic [2:0]  text_line;
		logic [4:0]  start_column;
	} num_item_t;

	typedef struct packed {
		logic [2:0] line;
		logic [5:0] column;
		logic [6:0] code;
		logic       last;
	} disp_char_t;

	typedef enum logic [1:0] {RX_FREE, RX_RANDOM, RX_PATTERN} rx_style_t;

	localparam int HOLD_CYCLES  = 200;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;
	localparam logic [12:0] RX_MASK = 13'b1_0110_1110_0101;

	logic clk;
	logic arst_n;

	n2a_in_if  num_if ();
	n2a_out_if chr_if ();

	number_to_ascii_digits dut (
		.clk    (clk),
		.arst_n (arst_n),
		.num    (num_if),
		.chr    (chr_if)
	);

	disp_char_t char_q[$];
	int         mismatches = 0;
	rx_style_t  rx_style = RX_FREE;
	int         hold_token = 0;
	int         hold_seen = 0;
	int         hold_left = 0;
	int         rx_phase = 0;
	int         idle_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Expected characters of one number, appended to the queue.
	function automatic void predict_chars(input num_item_t it);
		logic [4:0]  lim;
		logic [4:0]  cnt;
		logic [31:0] radix;
		logic [31:0] mag;
		logic [31:0] dig [MAX_DIGITS];
		logic [31:0] d;
		logic [5:0]  col;
		disp_char_t  c;
		int          i;
		case (it.mode)
			MODE_HEX: begin
				lim = LIM_HEX;
				radix = 16;
			end
			MODE_BIN: begin
				lim = LIM_BIN;
				radix = 2;
			end
			default: begin
				lim = LIM_DEC;
				radix = 10;
			end
		endcase
		cnt = (it.digit_count > lim) ? lim : it.digit_count;
		mag = it.value;
		col = {1'b0, it.start_column};
		c.line = it.text_line;
		if (it.mode == MODE_SDEC) begin
			c.column = col;
			c.code = it.value[31] ? CH_MINUS : CH_PLUS;
			c.last = (cnt == 5'd0);
			char_q.push_back(c);
			col = col + 6'd1;
			if (it.value[31]) begin
				mag = -it.value;
			end
		end
		for (i = 0; i < cnt; i++) begin
			dig[4'(i)] = mag % radix;
			mag = mag / radix;
		end
		for (i = 0; i < cnt; i++) begin
			d = dig[4'(int'(cnt) - 1 - i)];
			c.column = col + i[5:0];
			c.code = (d < 10) ? CH_ZERO + d[6:0] : CH_A + d[6:0] - 7'd10;
			c.last = (i == cnt - 1);
			char_q.push_back(c);
		end
	endfunction

	function automatic num_item_t make_number(input logic [1:0] mode, input logic [31:0] value,
			input logic [4:0] count, input logic [2:0] line, input logic [4:0] col);
		num_item_t it;
		it.mode = mode;
		it.value = value;
		it.digit_count = count;
		it.text_line = line;
		it.start_column = col;
		return it;
	endfunction

	function automatic logic [31:0] rand_value();
		logic [31:0] v;
		case ($urandom_range(4))
			0: v = $urandom_range(999);
			1: begin
				case ($urandom_range(6))
					0: v = 32'h0000_0000;
					1: v = 32'hFFFF_FFFF;
					2: v = 32'h8000_0000;
					3: v = 32'h7FFF_FFFF;
					4: v = 32'h8000_0001;
					5: v = 32'd1_000_000_000;
					default: v = 32'd999_999_999;
				endcase
			end
			2: v = $urandom >> $urandom_range(31);
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Mostly counts within the format's range; now and then zero or anything the field holds.
	function automatic num_item_t rand_number();
		num_item_t it;
		int        lim;
		int        r;
		it.mode = 2'($urandom_range(3));
		it.value = rand_value();
		lim = (it.mode == MODE_HEX) ? 8 : (it.mode == MODE_BIN) ? 16 : 10;
		r = $urandom_range(19);
		if (r == 0) begin
			it.digit_count = 5'd0;
		end else if (r <= 2) begin
			it.digit_count = 5'($urandom_range(31));
		end else begin
			it.digit_count = 5'($urandom_range(1, lim));
		end
		it.text_line = 3'($urandom_range(7));
		it.start_column = 5'($urandom_range(31));
		return it;
	endfunction

	// Offers one item and returns at the edge that accepts it; valid stays high.
	task automatic send_number(input num_item_t it);
		num_if.valid        <= 1'b1;
		num_if.mode         <= it.mode;
		num_if.value        <= it.value;
		num_if.digit_count  <= it.digit_count;
		num_if.text_line    <= it.text_line;
		num_if.start_column <= it.start_column;
		@(posedge clk);
		while (!num_if.ready) begin
			@(posedge clk);
		end
		predict_chars(it);
	endtask

	// Drops valid for a number of cycles, with junk on the payload.
	task automatic sender_gap(input int cycles);
		if (cycles > 0) begin
			num_if.valid        <= 1'b0;
			num_if.mode         <= 2'($urandom_range(3));
			num_if.value        <= $urandom;
			num_if.digit_count  <= 5'($urandom_range(31));
			num_if.text_line    <= 3'($urandom_range(7));
			num_if.start_column <= 5'($urandom_range(31));
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic wait_chars_drained();
		while (char_q.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic send_bursts(input int items);
		int sent;
		int burst;
		int j;
		sent = 0;
		while (sent < items) begin
			burst = $urandom_range(1, 12);
			for (j = 0; j < burst && sent < items; j++) begin
				send_number(rand_number());
				sent++;
			end
			if ($urandom_range(3) == 0) begin
				sender_gap($urandom_range(0, 24));
			end else begin
				sender_gap($urandom_range(0, 4));
			end
		end
	endtask

	task automatic test_directed_extremes();
		rx_style = RX_FREE;
		send_number(make_number(MODE_UDEC, 32'h0000_0000, 5'd10, 3'd0, 5'd0));
		send_number(make_number(MODE_UDEC, 32'hFFFF_FFFF, 5'd10, 3'd7, 5'd31));
		send_number(make_number(MODE_UDEC, 32'd123_456_789, 5'd31, 3'd1, 5'd1));
		send_number(make_number(MODE_UDEC, 32'hFFFF_FFFF, 5'd0, 3'd2, 5'd5));
		send_number(make_number(MODE_UDEC, 32'd1_000_000_000, 5'd9, 3'd3, 5'd16));
		send_number(make_number(MODE_UDEC, 32'd987_654_321, 5'd1, 3'd4, 5'd2));
		// The most negative value has no positive twin in 32 bits.
		send_number(make_number(MODE_SDEC, 32'h8000_0000, 5'd10, 3'd1, 5'd1));
		send_number(make_number(MODE_SDEC, 32'h7FFF_FFFF, 5'd16, 3'd2, 5'd3));
		send_number(make_number(MODE_SDEC, 32'hFFFF_FFFF, 5'd3, 3'd5, 5'd7));
		send_number(make_number(MODE_SDEC, 32'h0000_0000, 5'd0, 3'd6, 5'd9));
		send_number(make_number(MODE_SDEC, 32'h8000_0000, 5'd0, 3'd0, 5'd30));
		// Sign plus ten digits from the far right start column runs on to column 41.
		send_number(make_number(MODE_SDEC, 32'h8000_0000, 5'd31, 3'd7, 5'd31));
		send_number(make_number(MODE_HEX, 32'hDEAD_BEEF, 5'd8, 3'd1, 5'd4));
		send_number(make_number(MODE_HEX, 32'hFFFF_FFFF, 5'd31, 3'd3, 5'd8));
		send_number(make_number(MODE_HEX, 32'h0123_ABCD, 5'd0, 3'd4, 5'd12));
		send_number(make_number(MODE_HEX, 32'hFEDC_BA98, 5'd1, 3'd2, 5'd20));
		send_number(make_number(MODE_BIN, 32'hFFFF_A5A5, 5'd16, 3'd1, 5'd0));
		send_number(make_number(MODE_BIN, 32'hFFFF_FFFF, 5'd31, 3'd7, 5'd15));
		send_number(make_number(MODE_BIN, 32'h0000_0000, 5'd0, 3'd5, 5'd10));
		send_number(make_number(MODE_BIN, 32'h0000_8001, 5'd5, 3'd6, 5'd25));
		sender_gap(1);
		wait_chars_drained();
	endtask

	task automatic test_random_numbers();
		rx_style = RX_FREE;
		send_bursts(85);
		rx_style = RX_RANDOM;
		send_bursts(85);
		rx_style = RX_PATTERN;
		send_bursts(85);
		rx_style = RX_RANDOM;
		send_bursts(85);
	endtask

	// The receiver holds off on its own while items keep coming, so the input stalls.
	task automatic test_output_hold();
		int j;
		rx_style = RX_FREE;
		hold_token <= hold_token + 1;
		for (j = 0; j < 30; j++) begin
			send_number(rand_number());
		end
		sender_gap(1);
	endtask

	task automatic test_drain_pauses();
		int round;
		int j;
		rx_style = RX_PATTERN;
		for (round = 0; round < 6; round++) begin
			for (j = 0; j < 5; j++) begin
				send_number(rand_number());
			end
			sender_gap(1);
			wait_chars_drained();
		end
	endtask

	// Receiver: a long hold-off when asked, otherwise the current stall style.
	always @(posedge clk) begin
		rx_phase <= (rx_phase == 12) ? 0 : rx_phase + 1;
		if (hold_seen != hold_token) begin
			hold_seen <= hold_token;
			hold_left <= HOLD_CYCLES;
			chr_if.ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			chr_if.ready <= 1'b0;
		end else begin
			case (rx_style)
				RX_RANDOM: chr_if.ready <= ($urandom_range(99) < 65);
				RX_PATTERN: chr_if.ready <= RX_MASK[rx_phase[3:0]];
				default: chr_if.ready <= 1'b1;
			endcase
		end
	end

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : char_check
		disp_char_t want;
		if (arst_n && chr_if.valid && chr_if.ready) begin
			if (char_q.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual line %0d col %0d code %0d last %0d",
					$time, chr_if.out_line, chr_if.out_column, chr_if.char_code, chr_if.last);
				mismatches++;
			end else begin
				want = char_q.pop_front();
				check_field("out_line", want.line, chr_if.out_line);
				check_field("out_column", want.column, chr_if.out_column);
				check_field("char_code", want.code, chr_if.char_code);
				check_field("last", want.last, chr_if.last);
			end
		end
	end

	always @(posedge clk) begin
		if ((num_if.valid && num_if.ready) || (chr_if.valid && chr_if.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
			$display("tb_number_to_ascii_digits: FAIL");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		arst_n = 1'b0;
		num_if.valid = 1'b0;
		num_if.mode = MODE_UDEC;
		num_if.value = 32'd0;
		num_if.digit_count = 5'd0;
		num_if.text_line = 3'd0;
		num_if.start_column = 5'd0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_extremes();
		test_random_numbers();
		test_output_hold();
		test_drain_pauses();

		sender_gap(1);
		wait_chars_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0) begin
			$display("tb_number_to_ascii_digits: PASS");
		end else begin
			$display("tb_number_to_ascii_digits: FAIL");
		end
		$finish;
	end

endmodule
